// ----- rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Precedence parser stack package
// Shared types, constants and codes for the parser symbol stack.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned DepthDefault      = 64;
  localparam int unsigned SymbolBitsDefault = 6;
  localparam logic [5:0]  MarkerReset       = 6'd32;

  localparam logic [1:0] KindPush  = 2'd0;
  localparam logic [1:0] KindPop   = 2'd1;
  localparam logic [1:0] KindShift = 2'd2;
  localparam logic [1:0] KindClear = 2'd3;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusSyntax = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] symbol;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] top_symbol;
    logic       stack_empty;
    logic [5:0] top_terminal;
    logic       terminal_found;
    logic [6:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic shift_check;
    logic move_start;
    logic move_step;
    logic put_marker;
    logic put_symbol;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic move_done;
    logic full;
    logic shift_ok;
  } sts_t;

endpackage

// ----- rtl/pps_datapath.sv -----
// ----------------------------------------------------------------------------
// Precedence parser stack datapath
// Stack memory, counters, terminal scan and the result register.
// ----------------------------------------------------------------------------
module pps_datapath import pps_pkg::*; #(
  parameter int unsigned DEPTH       = DepthDefault,
  parameter int unsigned SYMBOL_BITS = SymbolBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [5:0] marker_i,
  input  req_t       req_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output rsp_t       rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [SYMBOL_BITS-1:0] mem_q [DEPTH];
  logic [SYMBOL_BITS-1:0] rd_q;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          term_pos_q, term_pos_d;
  logic                   found_q, found_d;
  logic [SYMBOL_BITS-1:0] term_q, term_d;
  logic [SYMBOL_BITS-1:0] top_q, top_d;
  logic [1:0]             status_q, status_d;
  logic [1:0]             kind_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic [SYMBOL_BITS-1:0] marker_sym;
  logic                   rd_lt;
  logic                   room;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SYMBOL_BITS-1:0] wr_data;
  logic [CW-1:0]          rd_ptr;
  logic [CW-1:0]          put_ptr;

  // The memory is read through a register, so each scan or move step has a read state and a compare or write state.
  assign rd_ptr     = ptr_q - CW'(1);
  assign marker_sym = SYMBOL_BITS'(marker_i);
  assign rd_lt      = 16'(rd_q) < 16'(marker_i);
  assign room       = ({1'b0, count_q} + (CW+1)'(2)) <= (CW+1)'(DEPTH);
  assign put_ptr    = (kind_q == KindShift) ? count_q + CW'(1) : count_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_q;
    if (cmd_i.move_step) begin
      wr_en   = 1'b1;
      wr_addr = ptr_q[AW-1:0];
    end else if (cmd_i.put_marker) begin
      wr_en   = 1'b1;
      wr_addr = AW'(term_pos_q + CW'(1));
      wr_data = marker_sym;
    end else if (cmd_i.put_symbol) begin
      wr_en   = 1'b1;
      wr_addr = AW'(put_ptr);
      wr_data = sym_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_ptr[AW-1:0]];
  end

  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    term_pos_d = term_pos_q;
    found_d    = found_q;
    term_d     = term_q;
    top_d      = top_q;
    status_d   = status_q;
    if (cmd_i.load) begin
      status_d = StatusOk;
      case (req_i.kind)
        KindPush: begin
          if (count_q >= CW'(DEPTH)) status_d = StatusFull;
        end
        KindPop: begin
          if (count_q != '0) count_d = count_q - CW'(1);
        end
        KindClear: count_d = '0;
        default: ;
      endcase
    end
    if (cmd_i.scan_start) begin
      ptr_d   = count_q;
      found_d = 1'b0;
      term_d  = '0;
      top_d   = '0;
    end
    if (cmd_i.scan_step) begin
      if (ptr_q == count_q) top_d = rd_q;
      if (rd_lt) begin
        found_d    = 1'b1;
        term_d     = rd_q;
        term_pos_d = rd_ptr;
      end
      ptr_d = rd_ptr;
    end
    if (cmd_i.shift_check) begin
      if (!found_q) begin
        status_d = StatusSyntax;
      end else if (!room) begin
        status_d = StatusFull;
      end
    end
    if (cmd_i.move_start) begin
      ptr_d = count_q;
    end
    if (cmd_i.move_step) begin
      ptr_d = rd_ptr;
    end
    if (cmd_i.put_symbol) begin
      if (kind_q == KindShift) begin
        count_d = count_q + CW'(2);
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_pos_q <= term_pos_d;
    term_q     <= term_d;
    top_q      <= top_d;
    status_q   <= status_d;
    if (cmd_i.load) begin
      kind_q <= req_i.kind;
      sym_q  <= SYMBOL_BITS'(req_i.symbol);
    end
  end

  assign sts_o.scan_done = (ptr_q == '0);
  assign sts_o.found     = found_q;
  assign sts_o.move_done = (ptr_q == term_pos_q + CW'(1));
  assign sts_o.full      = (count_q >= CW'(DEPTH));
  assign sts_o.shift_ok  = found_q && room;

  assign rsp_o.status         = status_q;
  assign rsp_o.top_symbol     = 6'(top_q);
  assign rsp_o.stack_empty    = (count_q == '0);
  assign rsp_o.top_terminal   = found_q ? 6'(term_q) : 6'd0;
  assign rsp_o.terminal_found = found_q;
  assign rsp_o.occupancy      = 7'(count_q);

endmodule

// ----- rtl/pps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Precedence parser stack controller
// Sequences one request through push, scan, move and result phases.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [1:0] in_kind_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StScanI   = 3'd1;
  localparam logic [2:0] StScanRd  = 3'd2;
  localparam logic [2:0] StScanCmp = 3'd3;
  localparam logic [2:0] StMoveRd  = 3'd4;
  localparam logic [2:0] StMoveWr  = 3'd5;
  localparam logic [2:0] StPut     = 3'd6;
  localparam logic [2:0] StOut     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pre_q, pre_d;

  always_comb begin
    state_d = state_q;
    pre_d   = pre_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pre_d      = 1'b0;
          case (in_kind_i)
            KindShift: begin
              cmd_o.scan_start = 1'b1;
              pre_d   = 1'b1;
              state_d = StScanRd;
            end
            KindPush: begin
              state_d = sts_i.full ? StScanI : StPut;
            end
            default: state_d = StScanI;
          endcase
        end
      end
      StScanI: begin
        cmd_o.scan_start = 1'b1;
        pre_d   = 1'b0;
        state_d = StScanRd;
      end
      StScanRd: begin
        if (sts_i.scan_done || sts_i.found) begin
          if (pre_q) begin
            cmd_o.shift_check = 1'b1;
            if (sts_i.shift_ok) begin
              cmd_o.move_start = 1'b1;
              state_d = StMoveRd;
            end else begin
              state_d = StOut;
            end
          end else begin
            state_d = StOut;
          end
        end else begin
          state_d = StScanCmp;
        end
      end
      StScanCmp: begin
        cmd_o.scan_step = 1'b1;
        state_d = StScanRd;
      end
      StMoveRd: begin
        if (sts_i.move_done) begin
          cmd_o.put_marker = 1'b1;
          state_d = StPut;
        end else begin
          state_d = StMoveWr;
        end
      end
      StMoveWr: begin
        cmd_o.move_step = 1'b1;
        state_d = StMoveRd;
      end
      StPut: begin
        cmd_o.put_symbol = 1'b1;
        state_d = StScanI;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pre_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pre_q   <= pre_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

endmodule

// ----- rtl/precedence_parser_stack.sv -----
// ----------------------------------------------------------------------------
// Precedence parser stack
// A result is presented once the stack has been scanned for its topmost terminal,
// after a pop, clear or refused push, and after a push once its symbol is written.
// A refused shift returns after its first scan; a done shift moves the non-terminals
// above the terminal up, writes the marker and the symbol, then scans again.
// One request is held at a time; the next is taken only after the result is accepted.
// Reset empties the stack and sets the marker to 32; entries stay undefined.
// ----------------------------------------------------------------------------
module precedence_parser_stack import pps_pkg::*; #(
  parameter int unsigned DEPTH       = DepthDefault,
  parameter int unsigned SYMBOL_BITS = SymbolBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o
);

  logic [5:0] marker_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       stall_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MarkerReset;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (stall_raw),
    .in_kind_i   (in_data_i.kind),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign in_stall_o = stall_raw;

  pps_datapath #(
    .DEPTH       (DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .marker_i (marker_q),
    .req_i    (in_data_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .rsp_o    (out_data_o)
  );

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.stack_empty == (out_data_o.occupancy == 7'd0)))
    else $error("empty flag disagrees with occupancy");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result waits");
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.occupancy <= 7'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule
